[sv/sm4_pkg.sv]
// Shared types, command codes and the SM4 T transform for the block cipher pipeline.
package sm4_pkg;

   localparam int NUM_ROUNDS_DEFAULT = 32;
   localparam int KEY_IDX_W = 5;
   localparam int WORD_W = 32;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } sm4_cmd_type;

   // One item as it moves down the pipeline. For a load, words[3] holds the key.
   typedef struct packed {
      sm4_cmd_type                  cmd;
      logic [KEY_IDX_W-1:0]         key_index;
      logic                         last;
      logic [3:0][WORD_W-1:0]       words;
   } sm4_item_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box followed by the linear rotate-and-XOR mix.
   function automatic logic [WORD_W-1:0] sm4_t(input logic [WORD_W-1:0] a);
      logic [WORD_W-1:0] b;
      b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

endpackage

[sv/sm4_round.sv]
// One SM4 round stage with its own round key register and pipeline register.
module sm4_round
   import sm4_pkg::*;
#(
   parameter int ROUND_IDX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  sm4_item_type in_item,
   output logic         out_valid,
   output sm4_item_type out_item
);

   localparam logic [KEY_IDX_W-1:0] MY_IDX = KEY_IDX_W'(ROUND_IDX);

   logic [WORD_W-1:0] rk_ff;
   logic              key_write;
   logic              valid_ff;
   sm4_item_type      item_ff;
   sm4_item_type      item_in;
   logic [WORD_W-1:0] t_word;

   assign key_write = advance && in_valid && (in_item.cmd == CMD_LOAD)
                      && (in_item.key_index == MY_IDX);

   always_comb begin
      t_word = in_item.words[0]
               ^ sm4_t(in_item.words[1] ^ in_item.words[2] ^ in_item.words[3] ^ rk_ff);
      item_in = in_item;
      if (in_item.cmd == CMD_ENCRYPT) begin
         item_in.words = {t_word, in_item.words[3], in_item.words[2], in_item.words[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (key_write) begin
         rk_ff <= in_item.words[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[sv/sm4_block_encrypt.sv]
// Top level of the pipelined SM4 ECB block encryptor with loadable round keys.
// The block is a chain of NUM_ROUNDS round stages, one register stage per round, and
// one item is accepted every cycle unless the pipeline holds; the last round register
// drives the result ports directly. Each round stage keeps its own round key. A load
// item travels down the same pipeline and writes its key as it passes the matching
// round, so every item sees exactly the keys loaded before it. Load items take a
// pipeline slot but produce no result. When a result is waiting and the result side
// stalls, the whole pipeline holds.
module sm4_block_encrypt
   import sm4_pkg::*;
#(
   parameter int NUM_ROUNDS = NUM_ROUNDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [KEY_IDX_W-1:0] req_key_index,
   input  logic [31:0]          req_key_word,
   input  logic [63:0]          req_block_hi,
   input  logic [63:0]          req_block_lo,
   input  logic                 req_last_block,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_cipher_hi,
   output logic [63:0]          rsp_cipher_lo,
   output logic                 rsp_last_out
);

   logic                      advance;
   logic         [NUM_ROUNDS:0] stage_valid;
   sm4_item_type              stage_item [NUM_ROUNDS+1];

   always_comb begin
      stage_item[0].cmd       = sm4_cmd_type'(req_cmd);
      stage_item[0].key_index = req_key_index;
      stage_item[0].last      = req_last_block;
      stage_item[0].words[0]  = req_block_hi[63:32];
      stage_item[0].words[1]  = req_block_hi[31:0];
      stage_item[0].words[2]  = req_block_lo[63:32];
      stage_item[0].words[3]  = (sm4_cmd_type'(req_cmd) == CMD_ENCRYPT) ?
                                req_block_lo[31:0] : req_key_word;
   end

   assign stage_valid[0] = req_valid;

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
      sm4_round #(
         .ROUND_IDX (i)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_item   (stage_item[i]),
         .out_valid (stage_valid[i+1]),
         .out_item  (stage_item[i+1])
      );
   end

   assign rsp_valid     = stage_valid[NUM_ROUNDS]
                          && (stage_item[NUM_ROUNDS].cmd == CMD_ENCRYPT);
   assign advance       = !(rsp_valid && rsp_stall);
   assign req_stall     = !advance;
   assign rsp_cipher_hi = {stage_item[NUM_ROUNDS].words[3], stage_item[NUM_ROUNDS].words[2]};
   assign rsp_cipher_lo = {stage_item[NUM_ROUNDS].words[1], stage_item[NUM_ROUNDS].words[0]};
   assign rsp_last_out  = stage_item[NUM_ROUNDS].last;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the SM4 block encryptor: random key loads and encrypts.
module tb_top;
   import sm4_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ROUNDS = NUM_ROUNDS_DEFAULT;
   localparam int ITEM_TARGET = 1350;
   localparam int STALL_PCT = 28;
   localparam int QUIET_START = 800;
   localparam int QUIET_END = 1300;
   localparam int HANG_LIMIT = 2000;

   localparam logic [7:0] SM4_SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   typedef struct packed {
      sm4_cmd_type          cmd;
      logic [KEY_IDX_W-1:0] key_index;
      logic [31:0]          key_word;
      logic [63:0]          block_hi;
      logic [63:0]          block_lo;
      logic                 last_block;
   } cmd_item_type;

   typedef struct packed {
      logic [63:0] cipher_hi;
      logic [63:0] cipher_lo;
      logic        last_out;
   } cipher_rec_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_cmd = 1'b0;
   logic [KEY_IDX_W-1:0] req_key_index = '0;
   logic [31:0]          req_key_word = '0;
   logic [63:0]          req_block_hi = '0;
   logic [63:0]          req_block_lo = '0;
   logic                 req_last_block = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [63:0]          rsp_cipher_hi;
   logic [63:0]          rsp_cipher_lo;
   logic                 rsp_last_out;

   cmd_item_type   queued_cmds[$];
   cipher_rec_type expected_ciphers[$];
   logic [31:0]    round_keys [NUM_ROUNDS];
   cmd_item_type   next_cmd;
   cipher_rec_type want;
   logic           req_fire = 1'b0;
   int             cycle_cnt = 0;
   int             hang_cycles = 0;
   int             error_count = 0;

   sm4_block_encrypt DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key_index  (req_key_index),
      .req_key_word   (req_key_word),
      .req_block_hi   (req_block_hi),
      .req_block_lo   (req_block_lo),
      .req_last_block (req_last_block),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cipher_hi  (rsp_cipher_hi),
      .rsp_cipher_lo  (rsp_cipher_lo),
      .rsp_last_out   (rsp_last_out)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] sm4_round_mix(input logic [31:0] a);
      logic [31:0] b;
      b = {SM4_SBOX[a[31:24]], SM4_SBOX[a[23:16]], SM4_SBOX[a[15:8]], SM4_SBOX[a[7:0]]};
      return b ^ ((b << 2) | (b >> 30)) ^ ((b << 10) | (b >> 22))
               ^ ((b << 18) | (b >> 14)) ^ ((b << 24) | (b >> 8));
   endfunction

   function automatic cipher_rec_type predict_ciphertext(input logic [63:0] hi,
                                                         input logic [63:0] lo,
                                                         input logic last);
      logic [31:0]    x [4];
      logic [31:0]    t;
      cipher_rec_type r;
      int             rnd;
      x[0] = hi[63:32];
      x[1] = hi[31:0];
      x[2] = lo[63:32];
      x[3] = lo[31:0];
      for (rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
         t = x[0] ^ sm4_round_mix(x[1] ^ x[2] ^ x[3] ^ round_keys[rnd]);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = t;
      end
      r.cipher_hi = {x[3], x[2]};
      r.cipher_lo = {x[1], x[0]};
      r.last_out = last;
      return r;
   endfunction

   function automatic bit take_break();
      return (cycle_cnt < QUIET_START || cycle_cnt >= QUIET_END)
             && ($urandom_range(99) < STALL_PCT);
   endfunction

   function automatic logic [63:0] rand_block();
      return {$urandom, $urandom};
   endfunction

   task automatic add_load(input logic [KEY_IDX_W-1:0] idx, input logic [31:0] key);
      cmd_item_type c;
      c.cmd = CMD_LOAD;
      c.key_index = idx;
      c.key_word = key;
      c.block_hi = rand_block();
      c.block_lo = rand_block();
      c.last_block = 1'($urandom_range(1));
      queued_cmds.push_back(c);
   endtask

   task automatic add_encrypt(input logic [63:0] hi, input logic [63:0] lo, input logic last);
      cmd_item_type c;
      c.cmd = CMD_ENCRYPT;
      c.key_index = KEY_IDX_W'($urandom_range(31));
      c.key_word = $urandom;
      c.block_hi = hi;
      c.block_lo = lo;
      c.last_block = last;
      queued_cmds.push_back(c);
   endtask

   // Driver: presents the next item once the current one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (queued_cmds.size() != 0 && !take_break()) begin
            next_cmd = queued_cmds.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_cmd.cmd;
            req_key_index <= next_cmd.key_index;
            req_key_word <= next_cmd.key_word;
            req_block_hi <= next_cmd.block_hi;
            req_block_lo <= next_cmd.block_lo;
            req_last_block <= next_cmd.last_block;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
      end
   end

   // Monitor: updates the key store, predicts on each accepted item, checks results.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_ciphers.size() == 0) begin
               $error("unexpected result: cipher_hi=%h cipher_lo=%h last_out=%b",
                      rsp_cipher_hi, rsp_cipher_lo, rsp_last_out);
               error_count = error_count + 1;
            end else begin
               want = expected_ciphers.pop_front();
               if (rsp_cipher_hi !== want.cipher_hi) begin
                  $error("cipher_hi: expected %h, actual %h", want.cipher_hi, rsp_cipher_hi);
                  error_count = error_count + 1;
               end
               if (rsp_cipher_lo !== want.cipher_lo) begin
                  $error("cipher_lo: expected %h, actual %h", want.cipher_lo, rsp_cipher_lo);
                  error_count = error_count + 1;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %b, actual %b", want.last_out, rsp_last_out);
                  error_count = error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_LOAD) begin
               round_keys[req_key_index] = req_key_word;
            end else begin
               expected_ciphers.push_back(
                  predict_ciphertext(req_block_hi, req_block_lo, req_last_block));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (queued_cmds.size() == 0 && !req_valid && expected_ciphers.size() == 0)) begin
            hang_cycles <= 0;
         end else if (hang_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            hang_cycles <= hang_cycles + 1;
         end
      end
   end

   initial begin
      int k;
      int pick;

      // Every round key is loaded before the first encrypt item.
      add_load(KEY_IDX_W'(0), 32'h0000_0000);
      add_load(KEY_IDX_W'(31), 32'hffff_ffff);
      for (k = 1; k < NUM_ROUNDS - 1; k++) begin
         add_load(KEY_IDX_W'(k), $urandom);
      end
      add_encrypt(64'h0, 64'h0, 1'b0);
      add_encrypt('1, '1, 1'b1);
      add_encrypt(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
      add_encrypt(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
      add_encrypt(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0);
      add_load(KEY_IDX_W'(0), 32'hffff_ffff);
      add_load(KEY_IDX_W'(31), 32'h0000_0000);
      add_encrypt(64'h0, 64'h0, 1'b1);
      add_encrypt(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
      add_load(KEY_IDX_W'(15), 32'h5a5a_a5a5);
      add_encrypt('1, '1, 1'b0);
      add_load(KEY_IDX_W'(15), 32'h0f0f_f0f0);
      add_encrypt('1, '1, 1'b1);

      while (queued_cmds.size() < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 1) begin
            for (k = 0; k < NUM_ROUNDS; k++) begin
               add_load(KEY_IDX_W'(k), $urandom);
            end
         end else if (pick < 25) begin
            add_load(KEY_IDX_W'($urandom_range(NUM_ROUNDS - 1)), $urandom);
         end else begin
            add_encrypt(rand_block(), rand_block(), 1'($urandom_range(1)));
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_cmds.size() != 0 || req_valid || expected_ciphers.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * NUM_ROUNDS) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
